### sv/cds_pkg.sv
// Shared types, status codes and calendar helpers for the date shifter.
package cds_pkg;

    localparam int YEAR_W = 14;
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YMOD_W = 9;
    localparam int ST_W   = 2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
    localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
    localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]  DAY_ONE  = 5'd1;
    localparam logic [DAY_W-1:0]  DAY_DEC  = 5'd31;
    localparam logic [YMOD_W-1:0] YMOD_TOP = 9'd399;

    typedef struct packed {
        logic              bad;
        logic              cmd;
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [YMOD_W-1:0] ymod;
    } t_job;

    // leap test from year mod 400
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
            && (ymod != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MON_FEB:                 len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### sv/cds_front.sv
// Front end: takes a command, reduces the year mod 400 and validates the date.
module cds_front
    import cds_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_cmd,
    input  logic [6:0]             i_in_day,
    input  logic [6:0]             i_in_month,
    input  logic [YEAR_W-1:0]      i_in_year,
    input  logic [COUNT_WIDTH-1:0] i_day_count,
    input  logic                   i_full,
    output logic                   o_busy,
    output logic                   o_push,
    output t_job                   o_job,
    output logic [COUNT_WIDTH-1:0] o_count
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;
    localparam logic [2:0] LAST_STEP = 3'd5;

    logic [1:0]             r_state, n_state;
    logic [2:0]             r_step, n_step;
    logic [YEAR_W-1:0]      r_rem, n_rem;
    logic                   r_cmd;
    logic [6:0]             r_day, r_month;
    logic [YEAR_W-1:0]      r_year;
    logic [COUNT_WIDTH-1:0] r_count;

    logic [YEAR_W-1:0] sub_k;
    logic              leap;
    logic              ok;

    // restoring reduction: 12800, 6400, ... 400
    always_comb begin
        unique case (r_step)
            3'd0:    sub_k = 14'd12800;
            3'd1:    sub_k = 14'd6400;
            3'd2:    sub_k = 14'd3200;
            3'd3:    sub_k = 14'd1600;
            3'd4:    sub_k = 14'd800;
            default: sub_k = 14'd400;
        endcase
    end

    assign leap = is_leap(r_rem[YMOD_W-1:0]);
    assign ok = (r_day != 7'd0) && (r_month != 7'd0) && (r_month <= 7'd12)
             && (r_year != 14'd0) && (r_year <= YEAR_MAX)
             && (r_day <= {2'b00, month_len(r_month[MON_W-1:0], leap)});

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_state = F_MOD;
                    n_step  = 3'd0;
                    n_rem   = i_in_year;
                end
            end
            F_MOD: begin
                if (r_rem >= sub_k) begin
                    n_rem = r_rem - sub_k;
                end
                n_step = r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        if (r_state == F_IDLE && i_start) begin
            r_cmd   <= i_cmd;
            r_day   <= i_in_day;
            r_month <= i_in_month;
            r_year  <= i_in_year;
            r_count <= i_day_count;
        end
    end

    assign o_busy      = (r_state != F_IDLE);
    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_job.bad   = !ok;
    assign o_job.cmd   = r_cmd;
    assign o_job.day   = r_day[DAY_W-1:0];
    assign o_job.month = r_month[MON_W-1:0];
    assign o_job.year  = r_year;
    assign o_job.ymod  = r_rem[YMOD_W-1:0];
    assign o_count     = r_count;

endmodule

### sv/cds_fifo.sv
// Two-entry queue between the front end and the stepping engine.
module cds_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr, r_rd;
    logic [1:0]        r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

### sv/cds_back.sv
// Stepping engine: moves the date one day per cycle and drives the result.
module cds_back
    import cds_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  t_job                   i_job,
    input  logic [COUNT_WIDTH-1:0] i_count,
    output logic                   o_pop,
    output logic                   o_done,
    output logic [DAY_W-1:0]       o_out_day,
    output logic [MON_W-1:0]       o_out_month,
    output logic [YEAR_W-1:0]      o_out_year,
    output logic [ST_W-1:0]        o_status
);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_RUN  = 1'b1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic                   r_state, n_state;
    logic                   r_cmd, n_cmd;
    logic [DAY_W-1:0]       r_day, n_day, r_oday, n_oday;
    logic [MON_W-1:0]       r_month, n_month, r_omonth, n_omonth;
    logic [YEAR_W-1:0]      r_year, n_year, r_oyear, n_oyear;
    logic [YMOD_W-1:0]      r_ymod, n_ymod;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_done, n_done;
    logic [DAY_W-1:0]       r_out_day, n_out_day;
    logic [MON_W-1:0]       r_out_month, n_out_month;
    logic [YEAR_W-1:0]      r_out_year, n_out_year;
    logic [ST_W-1:0]        r_status, n_status;

    logic             leap;
    logic [DAY_W-1:0] len_cur, len_prev;
    logic             hit;
    logic [DAY_W-1:0] s_day;
    logic [MON_W-1:0] s_month;
    logic [YEAR_W-1:0] s_year;
    logic [YMOD_W-1:0] s_ymod;

    assign leap     = is_leap(r_ymod);
    assign len_cur  = month_len(r_month, leap);
    assign len_prev = month_len(r_month - 4'd1, leap);

    // one day forward or back
    always_comb begin
        hit     = 1'b0;
        s_day   = r_day;
        s_month = r_month;
        s_year  = r_year;
        s_ymod  = r_ymod;
        if (!r_cmd) begin
            if (r_day != len_cur) begin
                s_day = r_day + 5'd1;
            end else if (r_month != MON_DEC) begin
                s_month = r_month + 4'd1;
                s_day   = DAY_ONE;
            end else if (r_year == YEAR_MAX) begin
                hit = 1'b1;
            end else begin
                s_year  = r_year + 14'd1;
                s_ymod  = (r_ymod == YMOD_TOP) ? 9'd0 : r_ymod + 9'd1;
                s_month = MON_JAN;
                s_day   = DAY_ONE;
            end
        end else begin
            if (r_day != DAY_ONE) begin
                s_day = r_day - 5'd1;
            end else if (r_month != MON_JAN) begin
                s_month = r_month - 4'd1;
                s_day   = len_prev;
            end else if (r_year == YEAR_MIN) begin
                hit = 1'b1;
            end else begin
                s_year  = r_year - 14'd1;
                s_ymod  = (r_ymod == 9'd0) ? YMOD_TOP : r_ymod - 9'd1;
                s_month = MON_DEC;
                s_day   = DAY_DEC;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_ymod      = r_ymod;
        n_oday      = r_oday;
        n_omonth    = r_omonth;
        n_oyear     = r_oyear;
        n_cnt       = r_cnt;
        n_done      = 1'b0;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;
        n_status    = r_status;
        o_pop       = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_job.bad) begin
                        n_done      = 1'b1;
                        n_out_day   = '0;
                        n_out_month = '0;
                        n_out_year  = '0;
                        n_status    = ST_BAD;
                    end else if (i_count == '0) begin
                        n_done      = 1'b1;
                        n_out_day   = i_job.day;
                        n_out_month = i_job.month;
                        n_out_year  = i_job.year;
                        n_status    = ST_OK;
                    end else begin
                        n_state  = B_RUN;
                        n_cmd    = i_job.cmd;
                        n_day    = i_job.day;
                        n_month  = i_job.month;
                        n_year   = i_job.year;
                        n_ymod   = i_job.ymod;
                        n_oday   = i_job.day;
                        n_omonth = i_job.month;
                        n_oyear  = i_job.year;
                        n_cnt    = i_count;
                    end
                end
            end
            B_RUN: begin
                if (hit) begin
                    n_state     = B_IDLE;
                    n_done      = 1'b1;
                    n_out_day   = r_oday;
                    n_out_month = r_omonth;
                    n_out_year  = r_oyear;
                    n_status    = ST_RANGE;
                end else begin
                    n_day   = s_day;
                    n_month = s_month;
                    n_year  = s_year;
                    n_ymod  = s_ymod;
                    n_cnt   = r_cnt - CNT_ONE;
                    if (r_cnt == CNT_ONE) begin
                        n_state     = B_IDLE;
                        n_done      = 1'b1;
                        n_out_day   = s_day;
                        n_out_month = s_month;
                        n_out_year  = s_year;
                        n_status    = ST_OK;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cmd       <= n_cmd;
        r_day       <= n_day;
        r_month     <= n_month;
        r_year      <= n_year;
        r_ymod      <= n_ymod;
        r_oday      <= n_oday;
        r_omonth    <= n_omonth;
        r_oyear     <= n_oyear;
        r_cnt       <= n_cnt;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
        r_status    <= n_status;
    end

    assign o_done      = r_done;
    assign o_out_day   = r_out_day;
    assign o_out_month = r_out_month;
    assign o_out_year  = r_out_year;
    assign o_status    = r_status;

endmodule

### sv/calendar_date_shift.sv
// Top level of the Gregorian date shifter.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------------
//  command   | i_start / o_busy    | i_cmd i_in_day i_in_month i_in_year i_day_count
//  result    | o_done (one cycle)  | o_out_day o_out_month o_out_year o_status
//
// Front end stays busy after it takes a transaction, through a 6-step mod-400 reduction
// of the year, then validation and queue write in the push state, so it takes no new
// command until that write is done; o_busy also stays high while the queue is full.
// Stepping engine loads a transaction from the queue while idle, then moves the date
// one day per cycle until the count is used up, taking no new transaction before then;
// the stepping loop sets the rate. Invalid dates and a zero count finish in the load cycle.
// Reset is synchronous and empties the queue; results cannot be stalled.
module calendar_date_shift
    import cds_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_cmd,
    input  logic [6:0]             i_in_day,
    input  logic [6:0]             i_in_month,
    input  logic [YEAR_W-1:0]      i_in_year,
    input  logic [COUNT_WIDTH-1:0] i_day_count,
    output logic                   o_done,
    output logic [DAY_W-1:0]       o_out_day,
    output logic [MON_W-1:0]       o_out_month,
    output logic [YEAR_W-1:0]      o_out_year,
    output logic [ST_W-1:0]        o_status
);

    localparam int DATA_W = $bits(t_job) + COUNT_WIDTH;

    logic                   push, pop, full, empty;
    t_job                   f_job, q_job;
    logic [COUNT_WIDTH-1:0] f_count, q_count;

    cds_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .i_in_day    (i_in_day),
        .i_in_month  (i_in_month),
        .i_in_year   (i_in_year),
        .i_day_count (i_day_count),
        .i_full      (full),
        .o_busy      (o_busy),
        .o_push      (push),
        .o_job       (f_job),
        .o_count     (f_count)
    );

    cds_fifo #(.DATA_W(DATA_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_job, f_count}),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  ({q_job, q_count})
    );

    cds_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (q_job),
        .i_count     (q_count),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_out_day   (o_out_day),
        .o_out_month (o_out_month),
        .o_out_year  (o_out_year),
        .o_status    (o_status)
    );

endmodule

### sv/cds_checker.sv
// Port-level checks for the date shifter, bound to the top level.
module cds_checker
    import cds_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_start,
    input logic                   o_busy,
    input logic                   o_done,
    input logic [DAY_W-1:0]       o_out_day,
    input logic [MON_W-1:0]       o_out_month,
    input logic [YEAR_W-1:0]      o_out_year,
    input logic [ST_W-1:0]        o_status
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_BAD || o_status == ST_RANGE))
        else $error("undefined status on result");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_BAD) |->
        (o_out_day == '0 && o_out_month == '0 && o_out_year == '0))
        else $error("invalid-date result carries a nonzero date");

    a_date_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_BAD) |->
        (o_out_day != '0 && o_out_month != '0 && o_out_month <= MON_DEC
         && o_out_year != '0 && o_out_year <= YEAR_MAX))
        else $error("result date out of calendar range");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("front end idle right after taking a transaction");

endmodule

bind calendar_date_shift cds_checker u_cds_checker (.*);
